### rtl/ilt_pkg.sv
// Package for the INI line tokenizer: parse phases, line classes and byte classes.
`default_nettype none

package ilt_pkg;

   typedef enum logic [3:0] {
      PH_LEAD,
      PH_COMMENT,
      PH_SECT_NAME,
      PH_SECT_TAIL,
      PH_SECT_DONE,
      PH_KEY,
      PH_EQ,
      PH_VALUE,
      PH_QUOTED,
      PH_VALUE_TAIL,
      PH_KV_PLAIN,
      PH_KV_QUOTED,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      CLS_BLANK   = 2'd0,
      CLS_SECTION = 2'd1,
      CLS_KEYVAL  = 2'd2,
      CLS_ERROR   = 2'd3
   } line_class_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_FIRST  = 8'd33;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB);
   endfunction

   function automatic logic is_normal(input logic [7:0] b);
      return (b >= CH_FIRST) && (b != CH_QUOTE) && (b != CH_SEMI) && (b != CH_HASH) &&
             (b != CH_LBRACK) && (b != CH_RBRACK) && (b != CH_EQUALS);
   endfunction

   function automatic logic is_stop(input logic [7:0] b);
      return (b == CH_SEMI) || (b == CH_HASH) || (b == CH_NUL);
   endfunction

endpackage : ilt_pkg

`default_nettype wire

### rtl/ini_line_tokenizer.sv
// Top level of the INI line tokenizer: per-byte parse state and the line result register.
`default_nettype none

// The tokenizer takes an INI text one byte per transaction and returns one
// result transaction for each line, issued when a newline byte or an end of
// input transaction closes that line. Carriage returns are dropped without a
// result. Every input transaction is handled as it is accepted: the per-byte
// parse state is updated at the edge at which the byte is accepted, and a
// closing transaction loads the line's classification into the result
// register at that same edge, so the result is offered in the next cycle. The
// block sustains one byte per cycle; it stalls the input only while a result
// waits in the result register and the downstream side is not taking it, as
// that single register is the only place where a result is held. There is no
// memory and no clearing pass, so the block is ready straight after reset.
// Lines holding more than MAX_LINE bytes are reported as syntax errors with
// too_long set and all positions zero; columns and lengths wrap modulo 256
// when MAX_LINE is above 256.
module ini_line_tokenizer #(
   parameter int MAX_LINE = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire logic [7:0]            req_byte_req,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ilt_pkg::line_class_type    rsp_line_class,
   output logic [15:0]                rsp_line_number,
   output logic [7:0]                 rsp_name_start,
   output logic [7:0]                 rsp_name_length,
   output logic [7:0]                 rsp_value_start,
   output logic [7:0]                 rsp_value_length,
   output logic                       rsp_value_quoted,
   output logic                       rsp_too_long,
   output logic                       rsp_is_last
);
   import ilt_pkg::*;

   // The column counter must be able to hold MAX_LINE itself.
   localparam int CW = $clog2(MAX_LINE + 1);

   // Per-line parse state.
   phase_type       phase_ff,            phase_in;
   logic [CW-1:0]   column_ff,           column_in;
   logic [7:0]      name_begin_ff,       name_begin_in;
   logic [7:0]      name_last_ff,        name_last_in;
   logic [7:0]      value_begin_ff,      value_begin_in;
   logic [7:0]      value_last_ff,       value_last_in;
   logic [15:0]     line_counter_ff,     line_counter_in;
   logic            overlong_ff,         overlong_in;

   // Result register.
   logic            rsp_valid_ff,        rsp_valid_in;
   line_class_type  res_class_ff,        res_class_in;
   logic [15:0]     res_line_ff;
   logic [7:0]      res_name_start_ff,   res_name_start_in;
   logic [7:0]      res_name_len_ff,     res_name_len_in;
   logic [7:0]      res_value_start_ff,  res_value_start_in;
   logic [7:0]      res_value_len_ff,    res_value_len_in;
   logic            res_quoted_ff,       res_quoted_in;
   logic            res_too_long_ff;
   logic            res_is_last_ff;

   logic            accept;
   logic            is_end;
   logic            is_lf;
   logic            is_cr;
   logic            closing;
   logic [7:0]      b;
   logic [7:0]      c8;

   // A new transaction can be taken whenever the result register is free or
   // is being emptied in this very cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign b       = req_byte_req;
   assign is_end  = (req_kind == KIND_END);
   assign is_lf   = (req_kind == KIND_DATA) && (b == CH_LF);
   assign is_cr   = (req_kind == KIND_DATA) && (b == CH_CR);
   assign closing = accept && (is_end || is_lf);
   assign c8      = column_ff[7:0];

   // Classification of the line as it stands, ready to be loaded into the
   // result register when the line is closed.
   always_comb begin
      res_class_in       = CLS_ERROR;
      res_name_start_in  = '0;
      res_name_len_in    = '0;
      res_value_start_in = '0;
      res_value_len_in   = '0;
      res_quoted_in      = 1'b0;
      if (!overlong_ff) begin
         case (phase_ff)
            PH_LEAD, PH_COMMENT: begin
               res_class_in = CLS_BLANK;
            end
            PH_SECT_TAIL, PH_SECT_DONE: begin
               res_class_in = CLS_SECTION;
            end
            PH_VALUE, PH_KV_PLAIN, PH_VALUE_TAIL, PH_KV_QUOTED: begin
               res_class_in       = CLS_KEYVAL;
               res_quoted_in      = (phase_ff == PH_VALUE_TAIL) ||
                                    (phase_ff == PH_KV_QUOTED);
               res_value_start_in = value_begin_ff;
               res_value_len_in   = value_last_ff + 8'd1 - value_begin_ff;
            end
            default: begin
               res_class_in = CLS_ERROR;
            end
         endcase
         if ((res_class_in == CLS_SECTION) || (res_class_in == CLS_KEYVAL)) begin
            res_name_start_in = name_begin_ff;
            res_name_len_in   = name_last_ff + 8'd1 - name_begin_ff;
         end
      end
   end

   // Next parse state for the accepted transaction.
   always_comb begin
      phase_in        = phase_ff;
      column_in       = column_ff;
      name_begin_in   = name_begin_ff;
      name_last_in    = name_last_ff;
      value_begin_in  = value_begin_ff;
      value_last_in   = value_last_ff;
      line_counter_in = line_counter_ff;
      overlong_in     = overlong_ff;

      if (closing) begin
         // A closed line starts the next one afresh; end of input also
         // restarts the line count for a following text.
         phase_in       = PH_LEAD;
         column_in      = '0;
         name_begin_in  = '0;
         name_last_in   = '0;
         value_begin_in = '0;
         value_last_in  = '0;
         overlong_in    = 1'b0;
         if (is_end) begin
            line_counter_in = 16'd1;
         end else if (line_counter_ff != LINE_MAX) begin
            line_counter_in = line_counter_ff + 16'd1;
         end
      end else if (accept && !is_cr && !overlong_ff) begin
         if (column_ff >= CW'(MAX_LINE)) begin
            // Once a line is too long the rest of it is ignored.
            overlong_in = 1'b1;
         end else begin
            column_in = column_ff + CW'(1);
            case (phase_ff)
               PH_LEAD: begin
                  if (is_ws(b)) begin
                  end else if (is_stop(b)) begin
                     phase_in = PH_COMMENT;
                  end else if (b == CH_LBRACK) begin
                     name_begin_in = c8 + 8'd1;
                     name_last_in  = c8;
                     phase_in      = PH_SECT_NAME;
                  end else if (is_normal(b)) begin
                     name_begin_in = c8;
                     name_last_in  = c8;
                     phase_in      = PH_KEY;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_SECT_NAME: begin
                  if (is_normal(b) || is_ws(b)) begin
                  end else if (b == CH_RBRACK) begin
                     name_last_in = c8 - 8'd1;
                     phase_in     = PH_SECT_TAIL;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_SECT_TAIL: begin
                  if (is_ws(b)) begin
                  end else if (is_stop(b)) begin
                     phase_in = PH_SECT_DONE;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_KEY: begin
                  if (is_normal(b)) begin
                     name_last_in = c8;
                  end else if (is_ws(b)) begin
                  end else if (b == CH_EQUALS) begin
                     phase_in = PH_EQ;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_EQ: begin
                  if (is_ws(b)) begin
                  end else if (b == CH_QUOTE) begin
                     value_begin_in = c8 + 8'd1;
                     value_last_in  = c8;
                     phase_in       = PH_QUOTED;
                  end else if (is_normal(b)) begin
                     value_begin_in = c8;
                     value_last_in  = c8;
                     phase_in       = PH_VALUE;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_VALUE: begin
                  if (is_normal(b)) begin
                     value_last_in = c8;
                  end else if (is_ws(b)) begin
                  end else if (is_stop(b)) begin
                     phase_in = PH_KV_PLAIN;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_QUOTED: begin
                  // Inside quotes anything goes except a zero byte.
                  if (b == CH_QUOTE) begin
                     value_last_in = c8 - 8'd1;
                     phase_in      = PH_VALUE_TAIL;
                  end else if (b == CH_NUL) begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_VALUE_TAIL: begin
                  if (is_ws(b)) begin
                  end else if (is_stop(b)) begin
                     phase_in = PH_KV_QUOTED;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               default: begin
                  // Comment, finished and error phases absorb the rest of the line.
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // The result register fills on a closing transaction and empties when the
   // downstream side takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (closing) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEAD;
         column_ff       <= '0;
         name_begin_ff   <= '0;
         name_last_ff    <= '0;
         value_begin_ff  <= '0;
         value_last_ff   <= '0;
         line_counter_ff <= 16'd1;
         overlong_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         column_ff       <= column_in;
         name_begin_ff   <= name_begin_in;
         name_last_ff    <= name_last_in;
         value_begin_ff  <= value_begin_in;
         value_last_ff   <= value_last_in;
         line_counter_ff <= line_counter_in;
         overlong_ff     <= overlong_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (closing) begin
         res_class_ff       <= res_class_in;
         res_line_ff        <= line_counter_ff;
         res_name_start_ff  <= res_name_start_in;
         res_name_len_ff    <= res_name_len_in;
         res_value_start_ff <= res_value_start_in;
         res_value_len_ff   <= res_value_len_in;
         res_quoted_ff      <= res_quoted_in;
         res_too_long_ff    <= overlong_ff;
         res_is_last_ff     <= is_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_class   = res_class_ff;
   assign rsp_line_number  = res_line_ff;
   assign rsp_name_start   = res_name_start_ff;
   assign rsp_name_length  = res_name_len_ff;
   assign rsp_value_start  = res_value_start_ff;
   assign rsp_value_length = res_value_len_ff;
   assign rsp_value_quoted = res_quoted_ff;
   assign rsp_too_long     = res_too_long_ff;
   assign rsp_is_last      = res_is_last_ff;

`ifndef SYNTHESIS
   // The column never runs past the line limit.
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff <= CW'(MAX_LINE))
      else $error("column counter beyond line limit");

   // An overlong line is always a syntax error with no positions.
   a_too_long_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_line_class == CLS_ERROR &&
      rsp_name_length == 8'd0 && rsp_value_length == 8'd0)
      else $error("overlong line reported with positions or wrong class");

   // Only key value lines carry a value.
   a_value_only_keyval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_class != CLS_KEYVAL |->
      rsp_value_start == 8'd0 && rsp_value_length == 8'd0 && !rsp_value_quoted)
      else $error("value fields set on a line without a value");

   // After end of input the line count restarts at one.
   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      closing && is_end |=> line_counter_ff == 16'd1)
      else $error("line count not restarted after end of input");
`endif

endmodule : ini_line_tokenizer

`default_nettype wire

### dv/ini_line_tokenizer_checker.sv
// Checker for the INI line tokenizer: watches both channels, predicts each line result and compares.
`timescale 1ns / 100ps

module ini_line_tokenizer_checker #(
   parameter int MAX_LINE = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_kind,
   input  logic [7:0]              req_byte_req,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ilt_pkg::line_class_type rsp_line_class,
   input  logic [15:0]             rsp_line_number,
   input  logic [7:0]              rsp_name_start,
   input  logic [7:0]              rsp_name_length,
   input  logic [7:0]              rsp_value_start,
   input  logic [7:0]              rsp_value_length,
   input  logic                    rsp_value_quoted,
   input  logic                    rsp_too_long,
   input  logic                    rsp_is_last,
   output int                      fail_count,
   output int                      pending
);
   import ilt_pkg::*;

   typedef struct {
      line_class_type line_class;
      logic [15:0]    line_number;
      logic [7:0]     name_start;
      logic [7:0]     name_length;
      logic [7:0]     value_start;
      logic [7:0]     value_length;
      logic           value_quoted;
      logic           too_long;
      logic           is_last;
   } line_result_type;

   line_result_type  expected_lines[$];
   line_result_type  seen;
   line_result_type  want;

   // Predicted parse state of the line in progress.
   phase_type   parse_state;
   int          col;
   int          name_first;
   int          name_last;
   int          value_first;
   int          value_last;
   logic [15:0] line_no;
   logic        overflowed;

   function automatic logic blank_byte(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB;
   endfunction

   function automatic logic plain_byte(input logic [7:0] b);
      return b >= CH_FIRST && !(b inside {CH_QUOTE, CH_SEMI, CH_HASH, CH_LBRACK,
                                          CH_RBRACK, CH_EQUALS});
   endfunction

   function automatic logic comment_byte(input logic [7:0] b);
      return b == CH_SEMI || b == CH_HASH || b == CH_NUL;
   endfunction

   function automatic string show(input line_result_type r);
      return $sformatf("class %0d line %0d name %0d+%0d value %0d+%0d quoted %0b long %0b last %0b",
                       r.line_class, r.line_number, r.name_start, r.name_length,
                       r.value_start, r.value_length, r.value_quoted, r.too_long, r.is_last);
   endfunction

   task automatic start_line();
      parse_state = PH_LEAD;
      col         = 0;
      name_first  = 0;
      name_last   = 0;
      value_first = 0;
      value_last  = 0;
      overflowed  = 1'b0;
   endtask

   task automatic absorb(input logic [7:0] b);
      int c;
      if (overflowed) return;
      if (col >= MAX_LINE) begin
         overflowed = 1'b1;
         return;
      end
      c   = col;
      col = col + 1;
      case (parse_state)
         PH_LEAD: begin
            if (blank_byte(b)) begin
            end else if (comment_byte(b)) begin
               parse_state = PH_COMMENT;
            end else if (b == CH_LBRACK) begin
               name_first  = c + 1;
               name_last   = c;
               parse_state = PH_SECT_NAME;
            end else if (plain_byte(b)) begin
               name_first  = c;
               name_last   = c;
               parse_state = PH_KEY;
            end else begin
               parse_state = PH_ERROR;
            end
         end
         PH_SECT_NAME: begin
            if (plain_byte(b) || blank_byte(b)) begin
            end else if (b == CH_RBRACK) begin
               name_last   = c - 1;
               parse_state = PH_SECT_TAIL;
            end else begin
               parse_state = PH_ERROR;
            end
         end
         PH_SECT_TAIL: begin
            if (blank_byte(b)) begin
            end else if (comment_byte(b)) begin
               parse_state = PH_SECT_DONE;
            end else begin
               parse_state = PH_ERROR;
            end
         end
         PH_KEY: begin
            if (plain_byte(b)) begin
               name_last = c;
            end else if (blank_byte(b)) begin
            end else if (b == CH_EQUALS) begin
               parse_state = PH_EQ;
            end else begin
               parse_state = PH_ERROR;
            end
         end
         PH_EQ: begin
            if (blank_byte(b)) begin
            end else if (b == CH_QUOTE) begin
               value_first = c + 1;
               value_last  = c;
               parse_state = PH_QUOTED;
            end else if (plain_byte(b)) begin
               value_first = c;
               value_last  = c;
               parse_state = PH_VALUE;
            end else begin
               parse_state = PH_ERROR;
            end
         end
         PH_VALUE: begin
            if (plain_byte(b)) begin
               value_last = c;
            end else if (blank_byte(b)) begin
            end else if (comment_byte(b)) begin
               parse_state = PH_KV_PLAIN;
            end else begin
               parse_state = PH_ERROR;
            end
         end
         PH_QUOTED: begin
            if (b == CH_QUOTE) begin
               value_last  = c - 1;
               parse_state = PH_VALUE_TAIL;
            end else if (b == CH_NUL) begin
               parse_state = PH_ERROR;
            end
         end
         PH_VALUE_TAIL: begin
            if (blank_byte(b)) begin
            end else if (comment_byte(b)) begin
               parse_state = PH_KV_QUOTED;
            end else begin
               parse_state = PH_ERROR;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic finish_line(input logic last);
      line_result_type r;
      int              span;
      r.line_class   = CLS_ERROR;
      r.name_start   = '0;
      r.name_length  = '0;
      r.value_start  = '0;
      r.value_length = '0;
      r.value_quoted = 1'b0;
      if (!overflowed) begin
         case (parse_state)
            PH_LEAD, PH_COMMENT: r.line_class = CLS_BLANK;
            PH_SECT_TAIL, PH_SECT_DONE: r.line_class = CLS_SECTION;
            PH_VALUE, PH_KV_PLAIN, PH_VALUE_TAIL, PH_KV_QUOTED: begin
               r.line_class   = CLS_KEYVAL;
               r.value_quoted = parse_state == PH_VALUE_TAIL || parse_state == PH_KV_QUOTED;
               span           = value_last + 1 - value_first;
               r.value_start  = value_first[7:0];
               r.value_length = span[7:0];
            end
            default: begin
            end
         endcase
         if (r.line_class == CLS_SECTION || r.line_class == CLS_KEYVAL) begin
            span          = name_last + 1 - name_first;
            r.name_start  = name_first[7:0];
            r.name_length = span[7:0];
         end
      end
      r.line_number = line_no;
      r.too_long    = overflowed;
      r.is_last     = last;
      expected_lines.push_back(r);
      if (last) line_no = 16'd1;
      else if (line_no != LINE_MAX) line_no = line_no + 16'd1;
      start_line();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_line();
         line_no = 16'd1;
         expected_lines.delete();
         fail_count = 0;
      end else begin
         // Results are registered and leave only after their line has closed, so the check comes first.
         if (rsp_valid && rsp_ready) begin
            seen.line_class   = rsp_line_class;
            seen.line_number  = rsp_line_number;
            seen.name_start   = rsp_name_start;
            seen.name_length  = rsp_name_length;
            seen.value_start  = rsp_value_start;
            seen.value_length = rsp_value_length;
            seen.value_quoted = rsp_value_quoted;
            seen.too_long     = rsp_too_long;
            seen.is_last      = rsp_is_last;
            if (expected_lines.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) $display("unexpected result: %s", show(seen));
            end else begin
               want = expected_lines.pop_front();
               if (want.line_class !== seen.line_class ||
                   want.line_number !== seen.line_number ||
                   want.name_start !== seen.name_start ||
                   want.name_length !== seen.name_length ||
                   want.value_start !== seen.value_start ||
                   want.value_length !== seen.value_length ||
                   want.value_quoted !== seen.value_quoted ||
                   want.too_long !== seen.too_long ||
                   want.is_last !== seen.is_last) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("wrong result at %0t\n  expected %s\n  actual   %s",
                              $realtime, show(want), show(seen));
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_END) finish_line(1'b1);
            else if (req_byte_req == CH_CR) begin
            end else if (req_byte_req == CH_LF) finish_line(1'b0);
            else absorb(req_byte_req);
         end
      end
      pending = expected_lines.size();
   end

endmodule

### dv/ini_line_tokenizer_tb.sv
// Testbench top for the INI line tokenizer: clock, reset, byte stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module ini_line_tokenizer_tb;
   import ilt_pkg::*;

   localparam int LINE_LIMIT = 256;

   // Every input of the block has a known value from time zero.
   logic           clock        = 1'b0;
   logic           reset        = 1'b1;
   logic           req_valid    = 1'b0;
   logic           req_kind     = KIND_DATA;
   logic [7:0]     req_byte_req = CH_NUL;
   logic           rsp_ready    = 1'b0;
   logic           req_ready;
   logic           rsp_valid;
   line_class_type rsp_line_class;
   logic [15:0]    rsp_line_number;
   logic [7:0]     rsp_name_start;
   logic [7:0]     rsp_name_length;
   logic [7:0]     rsp_value_start;
   logic [7:0]     rsp_value_length;
   logic           rsp_value_quoted;
   logic           rsp_too_long;
   logic           rsp_is_last;

   int fail_count;
   int pending;

   // Percentages of cycles in which the sender or the receiver holds back.
   int send_idle     = 36;
   int recv_idle     = 45;
   // The stimulus raises hold_requests to ask the receiver for one long stall.
   int hold_requests = 0;
   int hold_served   = 0;
   int items_sent    = 0;

   // The line being assembled before it is sent byte by byte.
   logic [7:0] line_buf[$];

   ini_line_tokenizer #(.MAX_LINE(LINE_LIMIT)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_byte_req     (req_byte_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_class   (rsp_line_class),
      .rsp_line_number  (rsp_line_number),
      .rsp_name_start   (rsp_name_start),
      .rsp_name_length  (rsp_name_length),
      .rsp_value_start  (rsp_value_start),
      .rsp_value_length (rsp_value_length),
      .rsp_value_quoted (rsp_value_quoted),
      .rsp_too_long     (rsp_too_long),
      .rsp_is_last      (rsp_is_last)
   );

   ini_line_tokenizer_checker #(.MAX_LINE(LINE_LIMIT)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_byte_req     (req_byte_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_class   (rsp_line_class),
      .rsp_line_number  (rsp_line_number),
      .rsp_name_start   (rsp_name_start),
      .rsp_name_length  (rsp_name_length),
      .rsp_value_start  (rsp_value_start),
      .rsp_value_length (rsp_value_length),
      .rsp_value_quoted (rsp_value_quoted),
      .rsp_too_long     (rsp_too_long),
      .rsp_is_last      (rsp_is_last),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always #1 clock = ~clock;

   // Safety net: the slowest legal run is well under a tenth of this.
   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Receiver. Ready is redrawn at every falling edge from the current idle
   // percentage. When the stimulus asks for it, ready is held low for a long
   // stretch counted here, so that the result register fills and the block
   // stops accepting bytes while the sender keeps offering them.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Offers one input transaction and returns at the falling edge after it has
   // been accepted. Valid is only lowered for an idle cycle, never between two
   // back-to-back transactions, and the payload is held until acceptance.
   task automatic send_item(input logic k, input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= k;
      req_byte_req <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent = items_sent + 1;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(KIND_DATA, s[i]);
   endtask

   task automatic send_lf();
      send_item(KIND_DATA, CH_LF);
   endtask

   function automatic logic [7:0] pick_space();
      return $urandom_range(1) ? CH_SPACE : CH_TAB;
   endfunction

   // Any byte that may stand in a name or a plain value, the top half included.
   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      b = 8'($urandom_range(255, 33));
      while (b inside {CH_QUOTE, CH_SEMI, CH_HASH, CH_LBRACK, CH_RBRACK, CH_EQUALS})
         b = 8'($urandom_range(255, 33));
      return b;
   endfunction

   function automatic logic [7:0] pick_loose();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (b == CH_LF) b = 8'($urandom_range(255));
      return b;
   endfunction

   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(8))
         0: return CH_LBRACK;
         1: return CH_RBRACK;
         2: return CH_EQUALS;
         3: return CH_QUOTE;
         4: return CH_SEMI;
         5: return CH_HASH;
         6: return CH_SPACE;
         7: return CH_TAB;
         default: return CH_NUL;
      endcase
   endfunction

   task automatic add_spaces(input int most);
      repeat ($urandom_range(most)) line_buf.push_back(pick_space());
   endtask

   // A key or plain value: it opens with a plain byte and may hold inner blanks.
   task automatic add_word(input int most);
      line_buf.push_back(pick_plain());
      repeat ($urandom_range(most))
         line_buf.push_back(($urandom_range(4) == 0) ? pick_space() : pick_plain());
   endtask

   // A comment opens with a semicolon, a hash or a zero byte, then anything goes.
   task automatic add_comment();
      case ($urandom_range(4))
         0: line_buf.push_back(CH_NUL);
         1, 2: line_buf.push_back(CH_SEMI);
         default: line_buf.push_back(CH_HASH);
      endcase
      repeat ($urandom_range(6)) line_buf.push_back(pick_loose());
   endtask

   task automatic maybe_comment();
      add_spaces(2);
      if ($urandom_range(1)) add_comment();
   endtask

   task automatic add_key_eq();
      add_spaces(2);
      add_word(5);
      add_spaces(2);
      line_buf.push_back(CH_EQUALS);
      add_spaces(2);
   endtask

   // Mostly well-formed lines with random content, so that every parse phase
   // is reached; the rest are noise, mutated lines and very long lines.
   task automatic build_line();
      int shape;
      int target;
      line_buf.delete();
      shape = $urandom_range(99);
      if (shape >= 96 && shape <= 97) add_spaces(0);
      if (shape < 10) begin
         add_spaces(3);
      end else if (shape < 25) begin
         add_spaces(2);
         add_comment();
      end else if (shape < 45) begin
         add_spaces(2);
         line_buf.push_back(CH_LBRACK);
         repeat ($urandom_range(6))
            line_buf.push_back(($urandom_range(4) == 0) ? pick_space() : pick_plain());
         line_buf.push_back(CH_RBRACK);
         maybe_comment();
      end else if (shape < 70) begin
         add_key_eq();
         add_word(6);
         maybe_comment();
      end else if (shape < 85) begin
         add_key_eq();
         line_buf.push_back(CH_QUOTE);
         repeat ($urandom_range(6)) begin
            if ($urandom_range(19) == 0) line_buf.push_back(CH_NUL);
            else line_buf.push_back(pick_loose() == CH_QUOTE ? CH_SPACE : pick_plain());
         end
         if ($urandom_range(3) == 0) line_buf.push_back(pick_loose());
         line_buf.push_back(CH_QUOTE);
         maybe_comment();
      end else if (shape < 96) begin
         repeat ($urandom_range(10, 1))
            line_buf.push_back($urandom_range(1) ? pick_symbol() : pick_loose());
      end else if (shape < 98) begin
         // Deep indentation pushes the columns towards and sometimes past the line limit.
         repeat ($urandom_range(250, 235)) line_buf.push_back(pick_space());
         if ($urandom_range(1)) begin
            line_buf.push_back(CH_LBRACK);
            add_word(4);
            line_buf.push_back(CH_RBRACK);
         end else begin
            add_word(4);
            line_buf.push_back(CH_EQUALS);
            add_word(8);
         end
      end else begin
         // A key/value line that ends just below, at or just above the limit.
         target = $urandom_range(LINE_LIMIT + 3, LINE_LIMIT - 2);
         line_buf.push_back(pick_plain());
         line_buf.push_back(CH_EQUALS);
         while (line_buf.size() < target) line_buf.push_back(pick_plain());
      end
      if (line_buf.size() > 0 && $urandom_range(99) < 8)
         line_buf[$urandom_range(line_buf.size() - 1)] =
            $urandom_range(1) ? pick_symbol() : pick_loose();
   endtask

   // Sends the assembled line with the odd carriage return mixed in, then
   // closes it by a newline, a CR LF pair or an end of input transaction.
   task automatic send_line();
      int term;
      foreach (line_buf[i]) begin
         if ($urandom_range(29) == 0) send_item(KIND_DATA, CH_CR);
         send_item(KIND_DATA, line_buf[i]);
      end
      term = $urandom_range(99);
      if (term < 5) begin
         send_item(KIND_END, 8'($urandom_range(255)));
      end else begin
         if (term < 10) send_item(KIND_DATA, CH_CR);
         send_lf();
      end
   endtask

   initial begin
      int target;
      int guard;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lines: blank, comments, sections (empty and untrimmed), plain
      // and quoted values, an empty key, an empty value, a zero byte inside a
      // quote, a zero byte as a comment start, a carriage return, a top-half
      // byte, and end of input both after text and on an empty line.
      send_lf();
      send_text("  \t; note");
      send_lf();
      send_text("# x");
      send_lf();
      send_text("[main]");
      send_lf();
      send_text(" [ a b ] ;c");
      send_lf();
      send_text("[]");
      send_lf();
      send_text("k = v w ;c");
      send_lf();
      send_text("k=\"\"");
      send_lf();
      send_text("k = \"x;y\" #t");
      send_lf();
      send_text("=v");
      send_lf();
      send_text("k=");
      send_lf();
      send_text("k=\"a");
      send_item(KIND_DATA, CH_NUL);
      send_text("\"");
      send_lf();
      send_item(KIND_DATA, CH_NUL);
      send_text("[z");
      send_lf();
      send_text("k=v");
      send_item(KIND_DATA, CH_NUL);
      send_text("=");
      send_lf();
      send_text("a b");
      send_item(KIND_DATA, CH_CR);
      send_lf();
      send_text("[s]x");
      send_lf();
      send_text("x=");
      send_item(KIND_DATA, 8'hFF);
      send_lf();
      send_text("end");
      send_item(KIND_END, 8'h00);
      send_text("[n]");
      send_item(KIND_END, 8'hFF);
      send_item(KIND_END, 8'h5A);

      // Random lines in three idling regimes; the long receiver stall is
      // requested as the second regime starts.
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle = 36;
               recv_idle = 45;
            end
            1: begin
               send_idle     = 45;
               recv_idle     = 36;
               hold_requests = hold_requests + 1;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         target = items_sent + 450;
         while (items_sent < target) begin
            build_line();
            send_line();
         end
      end

      // A final end of input, after which counting starts again from one.
      send_item(KIND_END, 8'h00);
      send_text("k=v");
      send_lf();

      req_valid <= 1'b0;
      guard = 0;
      while (pending != 0 && guard < 20000) begin
         @(negedge clock);
         guard = guard + 1;
      end
      repeat (5) @(negedge clock);
      if (fail_count == 0 && pending == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
rtl/ilt_pkg.sv
rtl/ini_line_tokenizer.sv
dv/ini_line_tokenizer_checker.sv
dv/ini_line_tokenizer_tb.sv
